[hdl/th_pkg.sv]
// Shared constants for the Toeplitz GF(2) hash block.
`timescale 1ns / 1ps

package th_pkg;

    // Width of the key, hash and matrix definition words.
    localparam int WORD_BITS = 32;

    // Width of the length registers.
    localparam int LEN_W = 6;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 4;

    // Default matrix dimensions.
    localparam int KEY_BITS_DEF = 32;
    localparam int OUT_BITS_DEF = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BITS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_BITS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN  = 4'd3;

    // Reset values of the configuration registers.
    localparam logic [WORD_BITS-1:0] ROW_BITS_RST = 32'd0;
    localparam logic [WORD_BITS-1:0] COL_BITS_RST = 32'd0;
    localparam logic [LEN_W-1:0]     KEY_LEN_RST  = 6'd8;
    localparam logic [LEN_W-1:0]     OUT_LEN_RST  = 6'd1;

endpackage

[hdl/toeplitz_hash_gf2.sv]
// Top level of the Toeplitz GF(2) hash: configuration, input stage and lane array.
`timescale 1ns / 1ps

// Each key word is multiplied by a binary Toeplitz matrix over GF(2): hash bit i is the
// parity of key bit j AND T[i][j] over j below key_len, with T built from col_bits (on and
// below the diagonal) and row_bits (above it). One key word is taken every clock cycle
// while the output is not stalled. The accepting edge loads the input register, and the
// result is loaded into the output register when that register can take it; the array of
// one lane per hash bit sits between the two registers. Output back-pressure stalls both
// stages. Configuration writes are accepted at any time and should be made while no
// transaction is in flight.
module toeplitz_hash_gf2 #(
    parameter int KEY_BITS = th_pkg::KEY_BITS_DEF,
    parameter int OUT_BITS = th_pkg::OUT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [th_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [th_pkg::WORD_BITS-1:0]   cfg_data,
    input  logic                           key_valid,
    output logic                           key_ready,
    input  logic [th_pkg::WORD_BITS-1:0]   key_word,
    output logic                           hash_valid,
    input  logic                           hash_ready,
    output logic [th_pkg::WORD_BITS-1:0]   hash_word
);

    // Matrix width and height as far as the data words carry them.
    localparam int KEY_W = (KEY_BITS > th_pkg::WORD_BITS) ? th_pkg::WORD_BITS : KEY_BITS;
    localparam int LANES = (OUT_BITS > th_pkg::WORD_BITS) ? th_pkg::WORD_BITS : OUT_BITS;

    logic [th_pkg::WORD_BITS-1:0] row_bits_reg;
    logic [th_pkg::WORD_BITS-1:0] col_bits_reg;
    logic [th_pkg::LEN_W-1:0]     key_len_reg;
    logic [th_pkg::LEN_W-1:0]     out_len_reg;

    logic                         key_valid_reg;
    logic                         key_valid_next;
    logic [th_pkg::WORD_BITS-1:0] key_reg;
    logic [th_pkg::WORD_BITS-1:0] key_next;

    logic [LANES-1:0]             lane_bits;
    logic                         stage_adv;

    // Configuration registers; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bits_reg <= th_pkg::ROW_BITS_RST;
            col_bits_reg <= th_pkg::COL_BITS_RST;
            key_len_reg  <= th_pkg::KEY_LEN_RST;
            out_len_reg  <= th_pkg::OUT_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                th_pkg::REG_ROW_BITS: row_bits_reg <= cfg_data;
                th_pkg::REG_COL_BITS: col_bits_reg <= cfg_data;
                th_pkg::REG_KEY_LEN:  key_len_reg  <= cfg_data[th_pkg::LEN_W-1:0];
                th_pkg::REG_OUT_LEN:  out_len_reg  <= cfg_data[th_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clear key bits at and above the key length or the matrix width.
    always_comb
    begin
        key_next = '0;
        for (int j = 0; j < KEY_W; j++)
        begin
            key_next[j] = key_word[j] & (key_len_reg > th_pkg::LEN_W'(j));
        end
    end

    // Input stage takes a new key when empty or when the merging stage takes its contents.
    assign key_ready = !key_valid_reg || stage_adv;

    always_comb
    begin
        key_valid_next = key_valid_reg;
        if (key_ready)
        begin
            key_valid_next = key_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= 1'b0;
        end
        else
        begin
            key_valid_reg <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_valid && key_ready)
        begin
            key_reg <= key_next;
        end
    end

    // One lane per hash bit, all working on the same registered key.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        th_lane #(
            .LANE(i)
        ) u_lane (
            .row_bits(row_bits_reg),
            .col_bits(col_bits_reg),
            .key     (key_reg),
            .parity  (lane_bits[i])
        );
    end

    // Merge the lane bits into the output register.
    th_merge #(
        .LANES(LANES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_bits (lane_bits),
        .in_valid  (key_valid_reg),
        .in_take   (stage_adv),
        .out_len   (out_len_reg),
        .hash_valid(hash_valid),
        .hash_ready(hash_ready),
        .hash_word (hash_word)
    );

    // An accepted key occupies the input stage in the next cycle.
    a_key_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid && key_ready) |=> key_valid_reg)
        else $error("accepted key did not reach the input stage");

    // A stalled input stage keeps its key.
    a_key_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid_reg && !stage_adv) |=> (key_valid_reg && $stable(key_reg)))
        else $error("stalled input stage lost or changed its key");

    // A key leaving the input stage becomes a pending result.
    a_key_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid_reg && stage_adv) |=> hash_valid)
        else $error("key left the input stage without producing a result");

    // An empty input stage always accepts.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !key_valid_reg |-> key_ready)
        else $error("empty input stage refused a key");

endmodule

[hdl/th_lane.sv]
// One lane: a single hash bit as the parity of one matrix row ANDed with the key.
`timescale 1ns / 1ps

module th_lane #(
    parameter int LANE = 0
) (
    input  logic [th_pkg::WORD_BITS-1:0] row_bits,
    input  logic [th_pkg::WORD_BITS-1:0] col_bits,
    input  logic [th_pkg::WORD_BITS-1:0] key,
    output logic                         parity
);

    logic [th_pkg::WORD_BITS-1:0] mrow;

    // Matrix row LANE: the column word on and below the diagonal, the row word above it.
    for (genvar j = 0; j < th_pkg::WORD_BITS; j++) begin : g_row
        if (j <= LANE) begin : g_col
            assign mrow[j] = col_bits[LANE-j];
        end
        else begin : g_above
            assign mrow[j] = row_bits[j-LANE];
        end
    end

    // The key arrives with unused bits already cleared.
    assign parity = ^(mrow & key);

endmodule

[hdl/th_merge.sv]
// Merging stage: gathers the lane bits, trims to the output length and holds the result.
`timescale 1ns / 1ps

module th_merge #(
    parameter int LANES = th_pkg::OUT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [LANES-1:0]             lane_bits,
    input  logic                         in_valid,
    output logic                         in_take,
    input  logic [th_pkg::LEN_W-1:0]     out_len,
    output logic                         hash_valid,
    input  logic                         hash_ready,
    output logic [th_pkg::WORD_BITS-1:0] hash_word
);

    logic                         hash_valid_reg;
    logic                         hash_valid_next;
    logic [th_pkg::WORD_BITS-1:0] hash_word_reg;
    logic [th_pkg::WORD_BITS-1:0] hash_word_next;

    // The output register takes a new transaction when empty or being drained.
    assign in_take = !hash_valid_reg || hash_ready;

    // Keep lane bits below the output length; lanes beyond the array read as zero.
    always_comb
    begin
        hash_word_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            hash_word_next[i] = lane_bits[i] & (out_len > th_pkg::LEN_W'(i));
        end
    end

    always_comb
    begin
        hash_valid_next = hash_valid_reg;
        if (in_take)
        begin
            hash_valid_next = in_valid;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            hash_valid_reg <= hash_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (in_take && in_valid)
        begin
            hash_word_reg <= hash_word_next;
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash_word  = hash_word_reg;

endmodule
